[hdl/gfx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfx_pkg
// Shared types and constants of the GF(p^e) arithmetic block.
// ----------------------------------------------------------------------------
package gfx_pkg;

	localparam int MAX_DEGREE = 7;
	localparam int PR_DEPTH = 2 * MAX_DEGREE - 1;
	localparam int DIG_W = $clog2(MAX_DEGREE);
	localparam int PR_W = $clog2(PR_DEPTH);

	localparam logic [7:0] ORDER_LIMIT = 8'd254;
	localparam logic [7:0] CODE_CAP = 8'd255;

	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_MUL = 3'd1;
	localparam logic [2:0] KIND_NEG = 3'd2;
	localparam logic [2:0] KIND_INV = 3'd3;
	localparam logic [2:0] KIND_FROB = 3'd4;

	localparam logic [1:0] CFG_PRIME = 2'd0;
	localparam logic [1:0] CFG_DEGREE = 2'd1;
	localparam logic [1:0] CFG_MODULUS = 2'd2;

	// control of one step of the shared modular unit
	typedef struct packed {
		logic       dbl;
		logic       din;
		logic [7:0] r;
		logic [7:0] y;
	} modstep_ctl_t;

endpackage

[hdl/gfx_modstep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfx_modstep
// One step of the shared modulo-p unit: r' = ((2r + din) mod p + y) mod p,
// or (r + y) mod p without doubling. Also yields the division quotient bit.
// ----------------------------------------------------------------------------
module gfx_modstep import gfx_pkg::*; (
	input  logic [7:0]   p,
	input  modstep_ctl_t ctl,
	output logic [7:0]   res,
	output logic         qbit
);

	logic [8:0] p9;
	logic [8:0] t;
	logic [8:0] t1;
	logic [8:0] u;
	logic [8:0] u1;

	always_comb begin
		p9 = {1'b0, p};
		t = ctl.dbl ? {ctl.r, ctl.din} : {1'b0, ctl.r};
		qbit = (t >= p9);
		t1 = qbit ? (t - p9) : t;
		u = t1 + {1'b0, ctl.y};
		u1 = (u >= p9) ? (u - p9) : u;
		res = u1[7:0];
	end

endmodule

[hdl/gf_extension_field_arithmetic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf_extension_field_arithmetic
// Add, multiply, negate, inverse and Frobenius in GF(p^e), q = p^e <= 254.
// ----------------------------------------------------------------------------
// Usage: set prime, degree and modulus_code through the write port (cfg_we,
// cfg_index, cfg_data) while the block is idle. A request transaction on the
// input channel (kind, operand_a, operand_b) yields exactly one result
// transaction (value, status) on the output channel.
// One request at a time: in_ready is high only while the sequencer is idle.
// Division, sums and products use one modulo-p step unit, one step per cycle.
// Steps: form q and check, then split base-p digits (a; b for add/multiply;
//   modulus for multiply/inverse/Frobenius), then add/negate digit-wise,
//   multiply: digit products reduced by the modulus, inverse: up to q-1
//   multiplies, Frobenius: p multiplies; all but inverse rebuild the code.
// Error, unknown-kind and zero-inverse cases go from the check straight to
// the finish state.
// The result sits in an output register; a stalled receiver holds it and
// the next request is taken meanwhile, but its result waits for the slot.
// Reset clears the sequencer, the output valid and restores the registers
// to prime 2, degree 1, modulus 0. There is no clearing pass.
// ----------------------------------------------------------------------------
module gf_extension_field_arithmetic import gfx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] kind,
	input  logic [7:0] operand_a,
	input  logic [7:0] operand_b,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] value,
	output logic       status
);

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_QPOW   = 14'b00000000000010,
		S_CHECK  = 14'b00000000000100,
		S_DIV    = 14'b00000000001000,
		S_DIGIT  = 14'b00000000010000,
		S_LIN    = 14'b00000000100000,
		S_MSTART = 14'b00000001000000,
		S_PLD    = 14'b00000010000000,
		S_PBIT   = 14'b00000100000000,
		S_PADD   = 14'b00001000000000,
		S_LEAD   = 14'b00010000000000,
		S_MEND   = 14'b00100000000000,
		S_JOIN   = 14'b01000000000000,
		S_FIN    = 14'b10000000000000
	} state_t;

	typedef enum logic [1:0] {
		SRC_A = 2'd0,
		SRC_B = 2'd1,
		SRC_M = 2'd2
	} src_t;

	function automatic logic [3:0] bit_len(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int k = 0; k < 8; k++) begin
			if (v[k]) begin
				n = 4'(k + 1);
			end
		end
		return n;
	endfunction

	function automatic logic [7:0] neg_mod(input logic [7:0] v, input logic [7:0] p);
		return (v == 8'd0) ? 8'd0 : (p - v);
	endfunction

	state_t state_q;
	logic [7:0] prime_q;
	logic [2:0] degree_q;
	logic [7:0] modulus_q;
	logic [2:0] kind_q;
	logic [7:0] a_q;
	logic [7:0] b_q;
	logic [7:0] qacc_q;
	logic [2:0] cnt_q;
	src_t src_q;
	logic [7:0] dv_q;
	logic [7:0] qt_q;
	logic [7:0] r_q;
	logic [2:0] bcnt_q;
	logic [DIG_W-1:0] didx_q;
	logic [7:0] da_q [MAX_DEGREE];
	logic [7:0] db_q [MAX_DEGREE];
	logic [7:0] nm_q [MAX_DEGREE];
	logic [7:0] pr_q [PR_DEPTH];
	logic [DIG_W-1:0] i_q;
	logic [DIG_W-1:0] j_q;
	logic [PR_W-1:0] top_q;
	logic reduce_q;
	logic [7:0] xs_q;
	logic [7:0] ys_q;
	logic [7:0] lead_q;
	logic [7:0] cnd_q;
	logic [7:0] fcnt_q;
	logic [7:0] res_q;
	logic st_q;
	logic out_valid_q;
	logic [7:0] value_q;
	logic status_q;

	logic [3:0] pbits;
	logic usable;
	logic need_b;
	logic need_m;
	logic [2:0] e_last;
	logic [DIG_W-1:0] db_idx;
	logic [PR_W-1:0] tidx;
	logic [PR_W-1:0] pr_idx;
	logic [7:0] pr_rd;
	logic [7:0] mul_a;
	logic [15:0] mprod;
	logic [15:0] jsum;
	logic pr_one;
	logic [7:0] db_inc [MAX_DEGREE];
	logic carry;
	modstep_ctl_t ctl;
	logic [7:0] unit_res;
	logic unit_qbit;
	logic split_more;
	src_t split_nxt;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign value = value_q;
	assign status = status_q;

	gfx_modstep u_modstep (
		.p    (prime_q),
		.ctl  (ctl),
		.res  (unit_res),
		.qbit (unit_qbit)
	);

	always_comb begin
		pbits = bit_len(prime_q - 8'd1);
		usable = (prime_q >= 8'd2) && (degree_q != 3'd0) && (qacc_q <= ORDER_LIMIT);
		need_b = (kind_q == KIND_ADD) || (kind_q == KIND_MUL);
		need_m = (kind_q == KIND_MUL) || (kind_q == KIND_INV) || (kind_q == KIND_FROB);
		e_last = degree_q - 3'd1;
		db_idx = (state_q == S_LIN) ? i_q : j_q;
		if (reduce_q) begin
			tidx = top_q - {1'b0, degree_q} + {1'b0, i_q};
		end else begin
			tidx = {1'b0, i_q} + {1'b0, j_q};
		end
		case (state_q)
			S_LEAD:  pr_idx = top_q;
			S_JOIN:  pr_idx = {1'b0, didx_q};
			default: pr_idx = tidx;
		endcase
		pr_rd = pr_q[pr_idx];
		mul_a = (state_q == S_QPOW) ? qacc_q : res_q;
		mprod = 16'(mul_a) * 16'(prime_q);
		jsum = mprod + 16'(pr_rd);

		// product equals the field element one
		pr_one = (pr_q[0] == 8'd1);
		for (int d = 1; d < MAX_DEGREE; d++) begin
			if ((d < int'(degree_q)) && (pr_q[d] != 8'd0)) begin
				pr_one = 1'b0;
			end
		end

		// base-p increment of the inverse candidate
		carry = 1'b1;
		for (int d = 0; d < MAX_DEGREE; d++) begin
			db_inc[d] = db_q[d];
			if (carry) begin
				if (db_q[d] == prime_q - 8'd1) begin
					db_inc[d] = 8'd0;
				end else begin
					db_inc[d] = db_q[d] + 8'd1;
					carry = 1'b0;
				end
			end
		end

		// next digit source after the current split
		split_more = 1'b0;
		split_nxt = SRC_M;
		case (src_q)
			SRC_A: begin
				if (need_b) begin
					split_more = 1'b1;
					split_nxt = SRC_B;
				end else if (need_m) begin
					split_more = 1'b1;
					split_nxt = SRC_M;
				end
			end
			SRC_B: begin
				if (need_m) begin
					split_more = 1'b1;
					split_nxt = SRC_M;
				end
			end
			default: split_more = 1'b0;
		endcase

		ctl = '0;
		case (state_q)
			S_DIV: begin
				ctl.dbl = 1'b1;
				ctl.din = dv_q[7];
				ctl.r = r_q;
			end
			S_LIN: begin
				ctl.r = da_q[i_q];
				ctl.y = db_q[db_idx];
			end
			S_PBIT: begin
				ctl.dbl = 1'b1;
				ctl.r = r_q;
				ctl.y = xs_q[bcnt_q] ? ys_q : 8'd0;
			end
			S_PADD: begin
				ctl.r = r_q;
				ctl.y = pr_rd;
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prime_q <= 8'd2;
			degree_q <= 3'd1;
			modulus_q <= 8'd0;
			kind_q <= KIND_ADD;
			a_q <= 8'd0;
			b_q <= 8'd0;
			qacc_q <= 8'd1;
			cnt_q <= 3'd0;
			src_q <= SRC_A;
			dv_q <= 8'd0;
			qt_q <= 8'd0;
			r_q <= 8'd0;
			bcnt_q <= 3'd0;
			didx_q <= '0;
			for (int k = 0; k < MAX_DEGREE; k++) begin
				da_q[k] <= 8'd0;
				db_q[k] <= 8'd0;
				nm_q[k] <= 8'd0;
			end
			for (int k = 0; k < PR_DEPTH; k++) begin
				pr_q[k] <= 8'd0;
			end
			i_q <= '0;
			j_q <= '0;
			top_q <= '0;
			reduce_q <= 1'b0;
			xs_q <= 8'd0;
			ys_q <= 8'd0;
			lead_q <= 8'd0;
			cnd_q <= 8'd0;
			fcnt_q <= 8'd0;
			res_q <= 8'd0;
			st_q <= 1'b0;
			out_valid_q <= 1'b0;
			value_q <= 8'd0;
			status_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PRIME:   prime_q <= cfg_data;
					CFG_DEGREE:  degree_q <= cfg_data[2:0];
					CFG_MODULUS: modulus_q <= cfg_data;
					default:     ;
				endcase
			end

			// the finish state reloads the slot itself
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= kind;
						a_q <= operand_a;
						b_q <= operand_b;
						qacc_q <= 8'd1;
						cnt_q <= 3'd0;
						state_q <= S_QPOW;
					end
				end
				S_QPOW: begin
					if (cnt_q == degree_q) begin
						state_q <= S_CHECK;
					end else begin
						qacc_q <= (mprod > 16'(CODE_CAP)) ? CODE_CAP : mprod[7:0];
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_CHECK: begin
					res_q <= 8'd0;
					if (kind_q > KIND_FROB) begin
						st_q <= 1'b0;
						state_q <= S_FIN;
					end else if (!usable || (a_q >= qacc_q) || (need_b && (b_q >= qacc_q))) begin
						st_q <= 1'b1;
						state_q <= S_FIN;
					end else if ((kind_q == KIND_INV) && (a_q == 8'd0)) begin
						st_q <= 1'b0;
						state_q <= S_FIN;
					end else begin
						src_q <= SRC_A;
						dv_q <= a_q;
						r_q <= 8'd0;
						bcnt_q <= 3'd0;
						didx_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// restoring division by p, one dividend bit per cycle
					r_q <= unit_res;
					qt_q <= {qt_q[6:0], unit_qbit};
					dv_q <= {dv_q[6:0], 1'b0};
					bcnt_q <= bcnt_q + 3'd1;
					if (bcnt_q == 3'd7) begin
						state_q <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					case (src_q)
						SRC_A:   da_q[didx_q] <= r_q;
						SRC_B:   db_q[didx_q] <= r_q;
						default: nm_q[didx_q] <= neg_mod(r_q, prime_q);
					endcase
					r_q <= 8'd0;
					bcnt_q <= 3'd0;
					if (didx_q != e_last) begin
						dv_q <= qt_q;
						didx_q <= didx_q + DIG_W'(1);
						state_q <= S_DIV;
					end else if (split_more) begin
						src_q <= split_nxt;
						dv_q <= (split_nxt == SRC_B) ? b_q : modulus_q;
						didx_q <= '0;
						state_q <= S_DIV;
					end else begin
						i_q <= '0;
						case (kind_q) inside
							KIND_ADD, KIND_NEG: state_q <= S_LIN;
							KIND_MUL: state_q <= S_MSTART;
							default: begin
								// candidate or accumulator starts at one
								for (int k = 0; k < MAX_DEGREE; k++) begin
									db_q[k] <= (k == 0) ? 8'd1 : 8'd0;
								end
								cnd_q <= 8'd1;
								fcnt_q <= prime_q;
								state_q <= S_MSTART;
							end
						endcase
					end
				end
				S_LIN: begin
					pr_q[{1'b0, i_q}] <= (kind_q == KIND_ADD) ? unit_res
						: neg_mod(da_q[i_q], prime_q);
					if (i_q == e_last) begin
						res_q <= 8'd0;
						didx_q <= e_last;
						state_q <= S_JOIN;
					end else begin
						i_q <= i_q + DIG_W'(1);
					end
				end
				S_MSTART: begin
					for (int k = 0; k < PR_DEPTH; k++) begin
						pr_q[k] <= 8'd0;
					end
					i_q <= '0;
					j_q <= '0;
					reduce_q <= 1'b0;
					state_q <= S_PLD;
				end
				S_PLD: begin
					if (reduce_q) begin
						xs_q <= lead_q;
						ys_q <= nm_q[i_q];
					end else begin
						xs_q <= da_q[i_q];
						ys_q <= db_q[db_idx];
					end
					r_q <= 8'd0;
					bcnt_q <= 3'(pbits - 4'd1);
					state_q <= S_PBIT;
				end
				S_PBIT: begin
					// double-and-add modular product, msb first
					r_q <= unit_res;
					if (bcnt_q == 3'd0) begin
						state_q <= S_PADD;
					end else begin
						bcnt_q <= bcnt_q - 3'd1;
					end
				end
				S_PADD: begin
					pr_q[tidx] <= unit_res;
					if (!reduce_q) begin
						if (j_q != e_last) begin
							j_q <= j_q + DIG_W'(1);
							state_q <= S_PLD;
						end else if (i_q != e_last) begin
							i_q <= i_q + DIG_W'(1);
							j_q <= '0;
							state_q <= S_PLD;
						end else if (degree_q > 3'd1) begin
							reduce_q <= 1'b1;
							top_q <= {degree_q, 1'b0} - 4'd2;
							state_q <= S_LEAD;
						end else begin
							state_q <= S_MEND;
						end
					end else begin
						if (i_q != e_last) begin
							i_q <= i_q + DIG_W'(1);
							state_q <= S_PLD;
						end else if (top_q > {1'b0, degree_q}) begin
							top_q <= top_q - 4'd1;
							state_q <= S_LEAD;
						end else begin
							state_q <= S_MEND;
						end
					end
				end
				S_LEAD: begin
					// x^e = -m(x): fold the top coefficient down
					lead_q <= pr_rd;
					i_q <= '0;
					state_q <= S_PLD;
				end
				S_MEND: begin
					case (kind_q)
						KIND_INV: begin
							if (pr_one) begin
								res_q <= cnd_q;
								st_q <= 1'b0;
								state_q <= S_FIN;
							end else if (8'(cnd_q + 8'd1) == qacc_q) begin
								res_q <= 8'd0;
								st_q <= 1'b0;
								state_q <= S_FIN;
							end else begin
								cnd_q <= cnd_q + 8'd1;
								for (int k = 0; k < MAX_DEGREE; k++) begin
									db_q[k] <= db_inc[k];
								end
								state_q <= S_MSTART;
							end
						end
						KIND_FROB: begin
							if (fcnt_q == 8'd1) begin
								res_q <= 8'd0;
								didx_q <= e_last;
								state_q <= S_JOIN;
							end else begin
								fcnt_q <= fcnt_q - 8'd1;
								for (int k = 0; k < MAX_DEGREE; k++) begin
									db_q[k] <= pr_q[k];
								end
								state_q <= S_MSTART;
							end
						end
						default: begin
							res_q <= 8'd0;
							didx_q <= e_last;
							state_q <= S_JOIN;
						end
					endcase
				end
				S_JOIN: begin
					res_q <= jsum[7:0];
					if (didx_q == '0) begin
						st_q <= 1'b0;
						state_q <= S_FIN;
					end else begin
						didx_q <= didx_q - DIG_W'(1);
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						value_q <= res_q;
						status_q <= st_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a transaction is in progress");

	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PBIT) |-> ({1'b0, bcnt_q} < pbits))
		else $error("multiplier bit index beyond width of p-1");

	a_digit_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLD) |-> ((i_q < degree_q) && (j_q < degree_q)))
		else $error("digit index beyond degree");

	a_candidate_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_MEND) && (kind_q == KIND_INV)) |-> ((cnd_q != 8'd0) && (cnd_q < qacc_q)))
		else $error("inverse candidate outside the field");

	a_error_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> (value_q == 8'd0))
		else $error("error status with nonzero value");
`endif

endmodule
